// ===== hdl/vvp_pkg.sv =====
`default_nettype none
package vvp_pkg;

  // Default field widths.
  localparam int COORD_WIDTH_DEF  = 24;
  localparam int SCREEN_WIDTH_DEF = 16;

  // Rotation coefficients are Q1.14 in 16-bit registers.
  localparam int TRIG_WIDTH = 16;
  localparam int TRIG_SHIFT = 14;

  // Focal length 256 is a left shift by 8; the screen center is 256.
  localparam int FOCAL_SHIFT = 8;
  localparam int CENTRE      = 256;

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CAM_X     = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CAM_Y     = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CAM_Z     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COS_YAW   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIN_YAW   = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COS_PITCH = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIN_PITCH = 3'd6;

  // Reset value of the cosine registers (1.0 in Q1.14).
  localparam logic [TRIG_WIDTH-1:0] TRIG_ONE = 16'sd16384;

endpackage
`default_nettype wire

// ===== hdl/vertex_view_transform_project.sv =====
`default_nettype none
// Vertex view transform and perspective projection. Each transaction on the
// input channel carries one world vertex (signed Q15.8); the block subtracts
// the camera position, rotates by yaw and then pitch with the Q1.14 cosine
// and sine registers, and projects with focal length 256 about screen center
// (256,256), giving one saturated screen point per vertex. A vertex is taken
// every clock while the output is not stalled. The pipeline has six stages
// of subtract, multiply and add, one overflow check stage, then one stage
// per quotient bit in the two pipelined restoring dividers (SCREEN_WIDTH + 1
// bits), then the saturation register. A stall on the output holds the
// whole pipeline. Points at or behind the eye come out as (256,256).
module vertex_view_transform_project #(
  parameter int COORD_WIDTH  = vvp_pkg::COORD_WIDTH_DEF,
  parameter int SCREEN_WIDTH = vvp_pkg::SCREEN_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write,
  input  wire logic [vvp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [((COORD_WIDTH > vvp_pkg::TRIG_WIDTH) ? COORD_WIDTH
                      : vvp_pkg::TRIG_WIDTH)-1:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] vertex_x,
  input  wire logic signed [COORD_WIDTH-1:0] vertex_y,
  input  wire logic signed [COORD_WIDTH-1:0] vertex_z,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [SCREEN_WIDTH-1:0] screen_x,
  output logic signed [SCREEN_WIDTH-1:0] screen_y,
  output logic clamped
);
  import vvp_pkg::*;

  localparam int TW  = TRIG_WIDTH;
  localparam int DW  = COORD_WIDTH + 1;            // vertex minus camera
  localparam int P1W = DW + TW;                    // first rotation products
  localparam int X1W = COORD_WIDTH + 4;            // after yaw
  localparam int P2W = X1W + TW;                   // second rotation products
  localparam int Z2W = COORD_WIDTH + 7;            // after pitch
  localparam int NW  = COORD_WIDTH + 8 + FOCAL_SHIFT; // scaled numerators
  localparam int QB  = SCREEN_WIDTH + 1;           // quotient bits
  localparam int RW  = ((NW > Z2W + QB) ? NW : Z2W + QB) + 1;

  localparam logic [QB-1:0] SAT_HI = QB'((1 << (SCREEN_WIDTH - 1)) - 1);
  localparam logic [QB-1:0] SAT_LO_MAG = QB'(1 << (SCREEN_WIDTH - 1));
  localparam logic signed [SCREEN_WIDTH-1:0] OUT_HI =
    SCREEN_WIDTH'((1 << (SCREEN_WIDTH - 1)) - 1);
  localparam logic signed [SCREEN_WIDTH-1:0] OUT_LO =
    SCREEN_WIDTH'(-(1 << (SCREEN_WIDTH - 1)));
  localparam logic signed [SCREEN_WIDTH-1:0] OUT_CENTRE = SCREEN_WIDTH'(CENTRE);

  // Configuration registers.
  logic signed [COORD_WIDTH-1:0] cam_x, cam_y, cam_z;
  logic signed [TW-1:0] cos_yaw, sin_yaw, cos_pitch, sin_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x     <= '0;
      cam_y     <= '0;
      cam_z     <= '0;
      cos_yaw   <= TRIG_ONE;
      sin_yaw   <= '0;
      cos_pitch <= TRIG_ONE;
      sin_pitch <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CAM_X:     cam_x     <= cfg_data[COORD_WIDTH-1:0];
        REG_CAM_Y:     cam_y     <= cfg_data[COORD_WIDTH-1:0];
        REG_CAM_Z:     cam_z     <= cfg_data[COORD_WIDTH-1:0];
        REG_COS_YAW:   cos_yaw   <= cfg_data[TW-1:0];
        REG_SIN_YAW:   sin_yaw   <= cfg_data[TW-1:0];
        REG_COS_PITCH: cos_pitch <= cfg_data[TW-1:0];
        REG_SIN_PITCH: sin_pitch <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: subtract the camera position.
  logic v1;
  logic signed [DW-1:0] dx, dy, dz;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dx <= DW'(vertex_x) - DW'(cam_x);
      dy <= DW'(vertex_y) - DW'(cam_y);
      dz <= DW'(vertex_z) - DW'(cam_z);
    end
  end

  // Stage 2: yaw products.
  logic v2;
  logic signed [P1W-1:0] p_xc, p_zs, p_zc, p_xs;
  logic signed [DW-1:0] dy2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p_xc <= P1W'(dx) * P1W'(cos_yaw);
      p_zs <= P1W'(dz) * P1W'(sin_yaw);
      p_zc <= P1W'(dz) * P1W'(cos_yaw);
      p_xs <= P1W'(dx) * P1W'(sin_yaw);
      dy2  <= dy;
    end
  end

  // Stage 3: floor each product and combine into the yawed x and z.
  logic v3;
  logic signed [X1W-1:0] x1, z1;
  logic signed [DW-1:0] dy3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= X1W'(p_xc >>> TRIG_SHIFT) - X1W'(p_zs >>> TRIG_SHIFT);
      z1  <= X1W'(p_zc >>> TRIG_SHIFT) + X1W'(p_xs >>> TRIG_SHIFT);
      dy3 <= dy2;
    end
  end

  // Stage 4: pitch products.
  logic v4;
  logic signed [P2W-1:0] p_yc, p_zsp, p_zcp, p_ys;
  logic signed [X1W-1:0] x1_4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p_yc  <= P2W'(dy3) * P2W'(cos_pitch);
      p_zsp <= P2W'(z1) * P2W'(sin_pitch);
      p_zcp <= P2W'(z1) * P2W'(cos_pitch);
      p_ys  <= P2W'(dy3) * P2W'(sin_pitch);
      x1_4  <= x1;
    end
  end

  // Stage 5: pitched y and z.
  logic v5;
  logic signed [Z2W-1:0] y2, z2;
  logic signed [X1W-1:0] x1_5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      y2   <= Z2W'(p_yc >>> TRIG_SHIFT) - Z2W'(p_zsp >>> TRIG_SHIFT);
      z2   <= Z2W'(p_zcp >>> TRIG_SHIFT) + Z2W'(p_ys >>> TRIG_SHIFT);
      x1_5 <= x1_4;
    end
  end

  // Stage 6: scaled numerators as sign and magnitude.
  logic signed [NW-1:0] num_x, num_y;
  always_comb begin
    num_x = (NW'(z2) + NW'(x1_5)) <<< FOCAL_SHIFT;
    num_y = (NW'(z2) - NW'(y2)) <<< FOCAL_SHIFT;
  end

  logic v6;
  logic [1:0] neg6;
  logic [NW-1:0] mag6 [2];
  logic [Z2W-1:0] den6;
  logic pos6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      neg6[0] <= num_x[NW-1];
      neg6[1] <= num_y[NW-1];
      mag6[0] <= num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
      mag6[1] <= num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
      den6    <= z2;
      pos6    <= !z2[Z2W-1] && (z2 != '0);
    end
  end

  // Divider pipeline. Entry 0 holds the overflow check; entry k+1 follows
  // quotient bit QB-1-k. Both lanes share the divisor.
  logic           dvld [QB+1];
  logic           dpos [QB+1];
  logic [RW-1:0]  dden [QB+1];
  logic [RW-1:0]  drem [2][QB+1];
  logic [QB-1:0]  dquo [2][QB+1];
  logic           dneg [2][QB+1];
  logic           dovf [2][QB+1];

  always_ff @(posedge clk) begin
    if (rst) dvld[0] <= 1'b0;
    else if (en) dvld[0] <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dpos[0] <= pos6;
      dden[0] <= RW'(den6);
    end
  end

  genvar l, k;
  generate
    for (l = 0; l < 2; l++) begin : g_lane
      // Quotients of 2^QB or more saturate in any case.
      always_ff @(posedge clk) begin
        if (en) begin
          drem[l][0] <= RW'(mag6[l]);
          dquo[l][0] <= '0;
          dneg[l][0] <= neg6[l];
          dovf[l][0] <= RW'(mag6[l]) >= (RW'(den6) << QB);
        end
      end
      for (k = 0; k < QB; k++) begin : g_bit
        logic [RW-1:0] trial;
        logic          fits;
        assign trial = dden[k] << (QB - 1 - k);
        assign fits  = drem[l][k] >= trial;
        always_ff @(posedge clk) begin
          if (en) begin
            drem[l][k+1] <= fits ? drem[l][k] - trial : drem[l][k];
            dquo[l][k+1] <= dquo[l][k] | (fits ? QB'(1) << (QB - 1 - k) : '0);
            dneg[l][k+1] <= dneg[l][k];
            dovf[l][k+1] <= dovf[l][k];
          end
        end
      end
    end
    for (k = 0; k < QB; k++) begin : g_ctl
      always_ff @(posedge clk) begin
        if (rst) dvld[k+1] <= 1'b0;
        else if (en) dvld[k+1] <= dvld[k];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dpos[k+1] <= dpos[k];
          dden[k+1] <= dden[k];
        end
      end
    end
  endgenerate

  // Sign, saturation and the center point for points behind the eye.
  logic signed [SCREEN_WIDTH-1:0] res_next [2];
  logic [1:0] hit;
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      hit[i] = 1'b0;
      if (!dpos[QB]) begin
        res_next[i] = OUT_CENTRE;
      end else if (dneg[i][QB]) begin
        if (dovf[i][QB] || dquo[i][QB] > SAT_LO_MAG) begin
          res_next[i] = OUT_LO;
          hit[i]      = 1'b1;
        end else begin
          res_next[i] = SCREEN_WIDTH'(-dquo[i][QB]);
        end
      end else begin
        if (dovf[i][QB] || dquo[i][QB] > SAT_HI) begin
          res_next[i] = OUT_HI;
          hit[i]      = 1'b1;
        end else begin
          res_next[i] = SCREEN_WIDTH'(dquo[i][QB]);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dvld[QB];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      screen_x <= res_next[0];
      screen_y <= res_next[1];
      clamped  <= |hit;
    end
  end

  // A clamped result sits at one of the rails.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && clamped |-> screen_x == OUT_HI || screen_x == OUT_LO ||
                             screen_y == OUT_HI || screen_y == OUT_LO)
    else $error("clamped result not at a rail");

  // A point at or behind the eye comes out at the center, unclamped.
  assert property (@(posedge clk) disable iff (rst)
    en && dvld[QB] && !dpos[QB] |=> out_valid && screen_x == OUT_CENTRE &&
                                    screen_y == OUT_CENTRE && !clamped)
    else $error("point behind the eye not centered");

  // The final remainder is below the divisor for every lane in range.
  assert property (@(posedge clk) disable iff (rst)
    dvld[QB] && dpos[QB] && !dovf[0][QB] |-> drem[0][QB] < dden[QB])
    else $error("divider x remainder out of range");

  assert property (@(posedge clk) disable iff (rst)
    dvld[QB] && dpos[QB] && !dovf[1][QB] |-> drem[1][QB] < dden[QB])
    else $error("divider y remainder out of range");

endmodule
`default_nettype wire

// ===== tb/tb_vertex_view_transform_project.sv =====
`timescale 1ns / 1ps
module tb_vertex_view_transform_project;
  import vvp_pkg::*;

  localparam int CW = 24;
  localparam int SW = 16;
  localparam int LATENCY = 9 + SW;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic                 clamp;
  } point_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [CW-1:0] vertex_x, vertex_y, vertex_z;
  logic out_valid;
  logic out_stall;
  logic signed [SW-1:0] screen_x, screen_y;
  logic clamped;

  vertex_view_transform_project u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .screen_x(screen_x), .screen_y(screen_y), .clamped(clamped)
  );

  // Camera and rotation settings mirrored in the testbench.
  longint cam_x, cam_y, cam_z;
  longint cos_yaw, sin_yaw, cos_pitch, sin_pitch;

  vertex_t pending_vertices[$];
  point_t  expected_points[$];
  int      mismatches;
  longint  cycle_count;

  // Product of two signed values divided by 2^14, rounded toward minus infinity.
  function automatic longint mul_q14(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> TRIG_SHIFT;
  endfunction

  function automatic longint clip_screen(longint v, ref bit hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1;
      return hi;
    end
    if (v < lo) begin
      hit = 1;
      return lo;
    end
    return v;
  endfunction

  // Screen point that a world vertex lands on under the current camera.
  function automatic point_t project_vertex(vertex_t v);
    longint x, y, z, x1, z1, y2, z2, sx, sy;
    bit hit;
    point_t p;
    hit = 0;
    x = longint'(v.x) - cam_x;
    y = longint'(v.y) - cam_y;
    z = longint'(v.z) - cam_z;
    x1 = mul_q14(x, cos_yaw) - mul_q14(z, sin_yaw);
    z1 = mul_q14(z, cos_yaw) + mul_q14(x, sin_yaw);
    y2 = mul_q14(y, cos_pitch) - mul_q14(z1, sin_pitch);
    z2 = mul_q14(z1, cos_pitch) + mul_q14(y, sin_pitch);
    if (z2 > 0) begin
      sx = (256 * (z2 + x1)) / z2;
      sy = (256 * (z2 - y2)) / z2;
    end else begin
      sx = CENTRE;
      sy = CENTRE;
    end
    sx = clip_screen(sx, hit);
    sy = clip_screen(sy, hit);
    p.sx = sx[SW-1:0];
    p.sy = sy[SW-1:0];
    p.clamp = hit;
    return p;
  endfunction

  // Clock.
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_vertex_view_transform_project: done, errors");
      $finish;
    end
  end

  function automatic int random_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Driver: presents queued vertices, with random gaps between transactions.
  int send_gap;
  int send_burst;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      send_gap <= 0;
      send_burst <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_points.push_back(project_vertex(pending_vertices.pop_front()));
      end
      if (send_gap > 0) begin
        in_valid <= 0;
        send_gap <= send_gap - 1;
      end else if (pending_vertices.size() > 0) begin
        vertex_t nxt;
        nxt = pending_vertices[0];
        in_valid <= 1;
        vertex_x <= nxt.x;
        vertex_y <= nxt.y;
        vertex_z <= nxt.z;
        if (send_burst > 0) send_burst <= send_burst - 1;
        else begin
          send_gap <= random_gap();
          if ($urandom_range(0, 7) == 0) send_burst <= $urandom_range(20, 60);
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Vertices queued by the driver stay at the head until accepted; keep the
  // head aligned with the one on the port by popping on acceptance above.

  // Monitor: compares each output transaction with the oldest expectation.
  int stall_burst;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_burst <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected output transaction: %0d %0d %0d",
                     screen_x, screen_y, clamped);
        end else begin
          point_t e;
          e = expected_points.pop_front();
          if (e.sx !== screen_x || e.sy !== screen_y || e.clamp !== clamped) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                       e.sx, e.sy, e.clamp, screen_x, screen_y, clamped);
          end
        end
      end
      if (stall_burst > 0) begin
        stall_burst <= stall_burst - 1;
        out_stall <= 1;
      end else if ($urandom_range(0, 29) == 0) begin
        stall_burst <= $urandom_range(30, 80);
        out_stall <= 1;
      end else begin
        out_stall <= (random_gap() > 0) && ($urandom_range(0, 2) == 0);
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, longint value);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= value[CW-1:0];
    @(posedge clk);
    cfg_write <= 0;
    case (idx)
      REG_CAM_X:     cam_x = longint'($signed(value[CW-1:0]));
      REG_CAM_Y:     cam_y = longint'($signed(value[CW-1:0]));
      REG_CAM_Z:     cam_z = longint'($signed(value[CW-1:0]));
      REG_COS_YAW:   cos_yaw = longint'($signed(value[TRIG_WIDTH-1:0]));
      REG_SIN_YAW:   sin_yaw = longint'($signed(value[TRIG_WIDTH-1:0]));
      REG_COS_PITCH: cos_pitch = longint'($signed(value[TRIG_WIDTH-1:0]));
      REG_SIN_PITCH: sin_pitch = longint'($signed(value[TRIG_WIDTH-1:0]));
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_vertices.size() > 0 || expected_points.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $signed(CW'($urandom));
      1: return $signed(CW'(-8388608));
      2: return $signed(CW'(8388607));
      default: return $signed(CW'(int'($urandom_range(0, 40000)) - 20000));
    endcase
  endfunction

  // Mostly points in front of the camera, some anywhere.
  task automatic queue_random(int n);
    vertex_t v;
    repeat (n) begin
      v.x = rand_coord();
      v.y = rand_coord();
      v.z = rand_coord();
      if ($urandom_range(0, 3) != 0)
        v.z = $signed(CW'(cam_z + $urandom_range(1, 60000)));
      pending_vertices.push_back(v);
    end
  endtask

  task automatic random_trig_setting();
    int a;
    for (int r = REG_COS_YAW; r <= REG_SIN_PITCH; r++) begin
      a = $urandom_range(0, 5);
      if (a == 0) write_reg(r[CFG_INDEX_WIDTH-1:0], 16384);
      else if (a == 1) write_reg(r[CFG_INDEX_WIDTH-1:0], -16384);
      else if (a == 2) write_reg(r[CFG_INDEX_WIDTH-1:0], $urandom_range(0, 65535));
      else write_reg(r[CFG_INDEX_WIDTH-1:0], int'($urandom_range(0, 32768)) - 16384);
    end
  endtask

  // Stimulus: directed vertices, then random phases under several settings.
  initial begin
    vertex_t v;
    rst = 1;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    out_stall = 0;
    vertex_x = '0;
    vertex_y = '0;
    vertex_z = '0;
    mismatches = 0;
    cycle_count = 0;
    cam_x = 0; cam_y = 0; cam_z = 0;
    cos_yaw = 16384; sin_yaw = 0; cos_pitch = 16384; sin_pitch = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, points behind the eye, saturation, unit z.
    v = '{x: 0, y: 0, z: 256};                 pending_vertices.push_back(v);
    v = '{x: 0, y: 0, z: 0};                   pending_vertices.push_back(v);
    v = '{x: 100, y: -100, z: -1};             pending_vertices.push_back(v);
    v = '{x: 8388607, y: -8388608, z: 1};      pending_vertices.push_back(v);
    v = '{x: -8388608, y: 8388607, z: 1};      pending_vertices.push_back(v);
    v = '{x: 8388607, y: 8388607, z: 8388607}; pending_vertices.push_back(v);
    v = '{x: -8388608, y: -8388608, z: -8388608}; pending_vertices.push_back(v);
    v = '{x: 256, y: 256, z: 512};             pending_vertices.push_back(v);
    v = '{x: -1, y: 1, z: 2};                  pending_vertices.push_back(v);
    v = '{x: 127 * 256, y: 0, z: 256};         pending_vertices.push_back(v);
    v = '{x: 128 * 256, y: -128 * 256, z: 256}; pending_vertices.push_back(v);
    wait_idle();

    // Unused register index: the write must change nothing.
    write_reg(3'd7, 24'h123456);
    write_reg(REG_CAM_X, -8388608);
    write_reg(REG_CAM_Y, 8388607);
    write_reg(REG_CAM_Z, 1000);
    write_reg(REG_COS_YAW, -16384);
    write_reg(REG_SIN_YAW, 16384);
    write_reg(REG_COS_PITCH, 0);
    write_reg(REG_SIN_PITCH, -16384);
    v = '{x: 0, y: 0, z: 0};                   pending_vertices.push_back(v);
    v = '{x: 8388607, y: -8388608, z: 8388607}; pending_vertices.push_back(v);
    queue_random(8);
    wait_idle();

    // Trig registers out of the normal range, camera at the other extreme.
    write_reg(REG_CAM_X, 8388607);
    write_reg(REG_CAM_Y, -8388608);
    write_reg(REG_CAM_Z, -8388608);
    write_reg(REG_COS_YAW, 16'h8000);
    write_reg(REG_SIN_YAW, 16'h7fff);
    write_reg(REG_COS_PITCH, 16'h7fff);
    write_reg(REG_SIN_PITCH, 16'h8000);
    queue_random(40);
    wait_idle();

    // Random phases.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        write_reg(REG_CAM_X, 0); write_reg(REG_CAM_Y, 0); write_reg(REG_CAM_Z, 0);
        write_reg(REG_COS_YAW, 16384); write_reg(REG_SIN_YAW, 0);
        write_reg(REG_COS_PITCH, 16384); write_reg(REG_SIN_PITCH, 0);
      end else begin
        write_reg(REG_CAM_X, $urandom_range(0, 1) ? $urandom : int'($urandom_range(0, 20000)) - 10000);
        write_reg(REG_CAM_Y, $urandom_range(0, 1) ? $urandom : int'($urandom_range(0, 20000)) - 10000);
        write_reg(REG_CAM_Z, $urandom_range(0, 1) ? $urandom : int'($urandom_range(0, 20000)) - 10000);
        random_trig_setting();
      end
      queue_random(95);
      wait_idle();
    end

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("tb_vertex_view_transform_project: done, clean");
    end else begin
      $display("tb_vertex_view_transform_project: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/vvp_pkg.sv
hdl/vertex_view_transform_project.sv
tb/tb_vertex_view_transform_project.sv
